// ----- sv/smpu_pkg.sv -----
// Shared types, widths and codes for the selection mask pixel update block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package smpu_pkg;

    localparam int COORD_BITS = 13;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int PROD_W     = 2 * SQ_W;
    localparam int CMP_W      = PROD_W + 3;

    localparam int CH_W    = 8;
    localparam int CDIFF_W = CH_W + 1;
    localparam int CSQ_W   = 2 * CH_W;
    localparam int CSUM_W  = CSQ_W + 2;
    localparam int TLIM_W  = CH_W + 2;
    localparam int LIM_W   = CSUM_W + 1;

    localparam int MASK_W = 8;
    localparam logic [MASK_W-1:0] MASK_FULL  = 8'hFF;
    localparam logic [MASK_W-1:0] MASK_HALF  = 8'h80;
    localparam logic [MASK_W-1:0] MASK_EMPTY = 8'h00;

    // The queue depth must stay a power of two so that the pointers wrap.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam int BACK_STAGES   = 3;
    localparam int PIPE_CAPACITY = QUEUE_DEPTH + BACK_STAGES;
    localparam int PEND_W        = $clog2(PIPE_CAPACITY + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_COLOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOLERANCE = 3'd7;

    localparam logic [1:0] SHAPE_RECT    = 2'd0;
    localparam logic [1:0] SHAPE_ELLIPSE = 2'd1;
    localparam logic [1:0] SHAPE_COLOR   = 2'd2;

    localparam logic [1:0] OP_REPLACE  = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_SUBTRACT = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_RECT,
        MODE_ELLIPSE,
        MODE_COLOR
    } smpu_mode_t;

    typedef struct packed {
        logic [1:0]            shape_kind;
        logic [1:0]            combine_op;
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [COORD_BITS-1:0] box_right;
        logic [COORD_BITS-1:0] box_bottom;
        logic [31:0]           reference_color;
        logic [CH_W-1:0]       color_tolerance;
    } smpu_cfg_t;

    typedef struct packed {
        smpu_mode_t         mode;
        logic               sub;
        logic               in_box;
        logic [MASK_W-1:0]  old_mask;
        logic [MASK_W-1:0]  base;
        logic [DIFF_W-1:0]  dx;
        logic [DIFF_W-1:0]  dy;
        logic [DIFF_W-1:0]  w;
        logic [DIFF_W-1:0]  h;
        logic [CDIFF_W-1:0] dr;
        logic [CDIFF_W-1:0] dg;
        logic [CDIFF_W-1:0] db;
        logic [CDIFF_W-1:0] da;
    } smpu_item_t;

endpackage

`default_nettype wire

// ----- sv/smpu_front.sv -----
// Front end: accepts pixel words and classifies them into queue items.
// Depends on smpu_pkg.
`default_nettype none

module smpu_front (
    input  wire smpu_pkg::smpu_cfg_t              cfg,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire logic [smpu_pkg::COORD_BITS-1:0]  pixel_x,
    input  wire logic [smpu_pkg::COORD_BITS-1:0]  pixel_y,
    input  wire logic [smpu_pkg::MASK_W-1:0]      old_mask,
    input  wire logic [smpu_pkg::CH_W-1:0]        red,
    input  wire logic [smpu_pkg::CH_W-1:0]        green,
    input  wire logic [smpu_pkg::CH_W-1:0]        blue,
    input  wire logic [smpu_pkg::CH_W-1:0]        alpha,
    output logic                                  push_valid,
    input  wire                                   push_ready,
    output smpu_pkg::smpu_item_t                  push_item
);
    import smpu_pkg::*;

    logic signed [DIFF_W-1:0] x_ext;
    logic signed [DIFF_W-1:0] y_ext;
    logic signed [DIFF_W-1:0] l_ext;
    logic signed [DIFF_W-1:0] t_ext;
    logic signed [DIFF_W-1:0] r_ext;
    logic signed [DIFF_W-1:0] b_ext;
    logic signed [DIFF_W-1:0] sum_x;
    logic signed [DIFF_W-1:0] sum_y;
    logic signed [DIFF_W-1:0] cx;
    logic signed [DIFF_W-1:0] cy;
    logic                     in_box;
    logic                     op_ok;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        x_ext = $signed({pixel_x[COORD_BITS-1], pixel_x});
        y_ext = $signed({pixel_y[COORD_BITS-1], pixel_y});
        l_ext = $signed({cfg.box_left[COORD_BITS-1], cfg.box_left});
        t_ext = $signed({cfg.box_top[COORD_BITS-1], cfg.box_top});
        r_ext = $signed({cfg.box_right[COORD_BITS-1], cfg.box_right});
        b_ext = $signed({cfg.box_bottom[COORD_BITS-1], cfg.box_bottom});

        in_box = (x_ext >= l_ext) && (x_ext < r_ext) && (y_ext >= t_ext) && (y_ext < b_ext);

        // The centre is rounded toward zero, as a signed halving would not be.
        sum_x = l_ext + r_ext;
        sum_y = t_ext + b_ext;
        cx = (sum_x + $signed({{(DIFF_W-1){1'b0}}, sum_x[DIFF_W-1]})) >>> 1;
        cy = (sum_y + $signed({{(DIFF_W-1){1'b0}}, sum_y[DIFF_W-1]})) >>> 1;

        case (cfg.combine_op) inside
            OP_REPLACE, OP_ADD, OP_SUBTRACT: op_ok = 1'b1;
            default:                         op_ok = 1'b0;
        endcase

        push_item.mode = MODE_PASS;
        if (op_ok)
        begin
            unique case (cfg.shape_kind)
                SHAPE_RECT:    push_item.mode = MODE_RECT;
                SHAPE_ELLIPSE: push_item.mode = MODE_ELLIPSE;
                SHAPE_COLOR:   push_item.mode = MODE_COLOR;
                default:       push_item.mode = MODE_PASS;
            endcase
        end

        push_item.sub      = (cfg.combine_op == OP_SUBTRACT);
        push_item.in_box   = in_box;
        push_item.old_mask = old_mask;
        push_item.base     = (cfg.combine_op == OP_REPLACE) ? MASK_EMPTY : old_mask;
        push_item.dx       = x_ext - cx;
        push_item.dy       = y_ext - cy;
        push_item.w        = r_ext - l_ext;
        push_item.h        = b_ext - t_ext;
        push_item.dr = $signed({1'b0, red})   - $signed({1'b0, cfg.reference_color[23:16]});
        push_item.dg = $signed({1'b0, green}) - $signed({1'b0, cfg.reference_color[15:8]});
        push_item.db = $signed({1'b0, blue})  - $signed({1'b0, cfg.reference_color[7:0]});
        push_item.da = $signed({1'b0, alpha}) - $signed({1'b0, cfg.reference_color[31:24]});
    end

endmodule

`default_nettype wire

// ----- sv/smpu_queue.sv -----
// Short queue of classified items between the front end and the back end.
// Depends on smpu_pkg.
`default_nettype none

module smpu_queue (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push_valid,
    output logic                       push_ready,
    input  wire smpu_pkg::smpu_item_t  push_item,
    output logic                       pop_valid,
    input  wire                        pop_ready,
    output smpu_pkg::smpu_item_t       pop_item
);
    import smpu_pkg::*;

    smpu_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/smpu_back.sv -----
// Back end: squares, cross products and compares, then the output register.
// Depends on smpu_pkg.
`default_nettype none

module smpu_back (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire smpu_pkg::smpu_cfg_t           cfg,
    input  wire                                pop_valid,
    output logic                               pop_ready,
    input  wire smpu_pkg::smpu_item_t          pop_item,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [smpu_pkg::MASK_W-1:0]        new_mask
);
    import smpu_pkg::*;

    typedef struct packed {
        smpu_mode_t        mode;
        logic              sub;
        logic              in_box;
        logic [MASK_W-1:0] old_mask;
        logic [MASK_W-1:0] base;
        logic [SQ_W-1:0]   dx2;
        logic [SQ_W-1:0]   dy2;
        logic [SQ_W-1:0]   w2;
        logic [SQ_W-1:0]   h2;
        logic [SQ_W-1:0]   w12;
        logic [SQ_W-1:0]   h12;
        logic [CSQ_W-1:0]  sr;
        logic [CSQ_W-1:0]  sg;
        logic [CSQ_W-1:0]  sb;
        logic [CSQ_W-1:0]  sa;
        logic [LIM_W-1:0]  lim;
    } smpu_sq_t;

    typedef struct packed {
        smpu_mode_t        mode;
        logic              sub;
        logic              in_box;
        logic [MASK_W-1:0] old_mask;
        logic [MASK_W-1:0] base;
        logic [PROD_W-1:0] core_x;
        logic [PROD_W-1:0] core_y;
        logic [PROD_W-1:0] core_r;
        logic [PROD_W-1:0] ring_x;
        logic [PROD_W-1:0] ring_y;
        logic [PROD_W-1:0] ring_r;
        logic [CSUM_W-1:0] csum;
        logic [LIM_W-1:0]  lim;
    } smpu_prod_t;

    logic              advance;
    logic              v1_reg;
    logic              v2_reg;
    logic              out_valid_reg;
    smpu_sq_t          s1_reg;
    smpu_sq_t          s1_next;
    smpu_prod_t        s2_reg;
    smpu_prod_t        s2_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;

    logic signed [SQ_W-1:0]    dx_ext;
    logic signed [SQ_W-1:0]    dy_ext;
    logic [SQ_W-1:0]           w_ext;
    logic [SQ_W-1:0]           h_ext;
    logic [SQ_W-1:0]           w1_ext;
    logic [SQ_W-1:0]           h1_ext;
    logic signed [2*CDIFF_W-1:0] dr_ext;
    logic signed [2*CDIFF_W-1:0] dg_ext;
    logic signed [2*CDIFF_W-1:0] db_ext;
    logic signed [2*CDIFF_W-1:0] da_ext;
    logic signed [2*CDIFF_W-1:0] pr;
    logic signed [2*CDIFF_W-1:0] pg;
    logic signed [2*CDIFF_W-1:0] pb;
    logic signed [2*CDIFF_W-1:0] pa;
    logic [TLIM_W-1:0]         tlim;
    logic [CMP_W-1:0]          core_sum;
    logic [CMP_W-1:0]          ring_sum;
    logic                      core;
    logic                      ring;
    logic                      match;

    assign advance   = !out_valid_reg || out_ready;
    assign pop_ready = advance;
    assign out_valid = out_valid_reg;
    assign new_mask  = mask_reg;

    always_comb
    begin
        dx_ext = SQ_W'($signed(pop_item.dx));
        dy_ext = SQ_W'($signed(pop_item.dy));
        w_ext  = SQ_W'(pop_item.w);
        h_ext  = SQ_W'(pop_item.h);
        w1_ext = w_ext + SQ_W'(1);
        h1_ext = h_ext + SQ_W'(1);
        dr_ext = (2*CDIFF_W)'($signed(pop_item.dr));
        dg_ext = (2*CDIFF_W)'($signed(pop_item.dg));
        db_ext = (2*CDIFF_W)'($signed(pop_item.db));
        da_ext = (2*CDIFF_W)'($signed(pop_item.da));
        pr = dr_ext * dr_ext;
        pg = dg_ext * dg_ext;
        pb = db_ext * db_ext;
        pa = da_ext * da_ext;

        // floor(sqrt(s)) / 2 <= tol holds exactly when s < (2 * tol + 2)^2.
        tlim = {1'b0, cfg.color_tolerance, 1'b0} + TLIM_W'(2);

        s1_next.mode     = pop_item.mode;
        s1_next.sub      = pop_item.sub;
        s1_next.in_box   = pop_item.in_box;
        s1_next.old_mask = pop_item.old_mask;
        s1_next.base     = pop_item.base;
        s1_next.dx2      = $unsigned(dx_ext * dx_ext);
        s1_next.dy2      = $unsigned(dy_ext * dy_ext);
        s1_next.w2       = w_ext * w_ext;
        s1_next.h2       = h_ext * h_ext;
        s1_next.w12      = w1_ext * w1_ext;
        s1_next.h12      = h1_ext * h1_ext;
        s1_next.sr       = pr[CSQ_W-1:0];
        s1_next.sg       = pg[CSQ_W-1:0];
        s1_next.sb       = pb[CSQ_W-1:0];
        s1_next.sa       = pa[CSQ_W-1:0];
        s1_next.lim      = LIM_W'(tlim) * LIM_W'(tlim);
    end

    always_comb
    begin
        s2_next.mode     = s1_reg.mode;
        s2_next.sub      = s1_reg.sub;
        s2_next.in_box   = s1_reg.in_box;
        s2_next.old_mask = s1_reg.old_mask;
        s2_next.base     = s1_reg.base;
        s2_next.core_x   = PROD_W'(s1_reg.dx2) * PROD_W'(s1_reg.h2);
        s2_next.core_y   = PROD_W'(s1_reg.dy2) * PROD_W'(s1_reg.w2);
        s2_next.core_r   = PROD_W'(s1_reg.w2) * PROD_W'(s1_reg.h2);
        s2_next.ring_x   = PROD_W'(s1_reg.dx2) * PROD_W'(s1_reg.h12);
        s2_next.ring_y   = PROD_W'(s1_reg.dy2) * PROD_W'(s1_reg.w12);
        s2_next.ring_r   = PROD_W'(s1_reg.w12) * PROD_W'(s1_reg.h12);
        s2_next.csum     = CSUM_W'(s1_reg.sr) + CSUM_W'(s1_reg.sg)
                         + CSUM_W'(s1_reg.sb) + CSUM_W'(s1_reg.sa);
        s2_next.lim      = s1_reg.lim;
    end

    always_comb
    begin
        core_sum = (CMP_W'(s2_reg.core_x) + CMP_W'(s2_reg.core_y)) << 2;
        ring_sum = (CMP_W'(s2_reg.ring_x) + CMP_W'(s2_reg.ring_y)) << 2;
        core  = s2_reg.in_box && (core_sum <= CMP_W'(s2_reg.core_r));
        ring  = s2_reg.in_box && !core && (ring_sum <= CMP_W'(s2_reg.ring_r));
        match = LIM_W'(s2_reg.csum) < s2_reg.lim;

        mask_next = s2_reg.old_mask;
        unique case (s2_reg.mode)
            MODE_RECT:
            begin
                if (s2_reg.in_box)
                begin
                    mask_next = s2_reg.sub ? MASK_EMPTY : MASK_FULL;
                end
                else
                begin
                    mask_next = s2_reg.base;
                end
            end
            MODE_ELLIPSE:
            begin
                if (core)
                begin
                    mask_next = s2_reg.sub ? MASK_EMPTY : MASK_FULL;
                end
                else if (ring && s2_reg.sub)
                begin
                    mask_next = (s2_reg.old_mask < MASK_HALF) ? s2_reg.old_mask : MASK_HALF;
                end
                else if (ring)
                begin
                    mask_next = (s2_reg.base > MASK_HALF) ? s2_reg.base : MASK_HALF;
                end
                else
                begin
                    mask_next = s2_reg.base;
                end
            end
            MODE_COLOR:
            begin
                if (s2_reg.sub)
                begin
                    mask_next = s2_reg.old_mask;
                end
                else
                begin
                    mask_next = match ? MASK_FULL : s2_reg.base;
                end
            end
            default:
            begin
                mask_next = s2_reg.old_mask;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            mask_reg <= mask_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/selection_mask_pixel_update.sv -----
// Top level of the selection mask pixel update block: configuration registers,
// front end, item queue and back end. Depends on smpu_pkg, smpu_front,
// smpu_queue and smpu_back.
//
//   Channel   Handshake                Payload
//   ------    ---------------------    ------------------------------------------
//   cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//   in        in_valid / in_ready      pixel_x, pixel_y, old_mask, red..alpha
//   out       out_valid / out_ready    new_mask
//
// One pixel word is accepted every cycle while the queue is not full; a result passes
// through the queue entry, two arithmetic stages and the output register.
// Reset clears the queue pointers, the stage valid bits and the configuration
// registers to zero.
// A stalled output freezes the back end; the four-entry queue keeps taking
// words until it fills, and then in_ready falls. cfg_ready is always high.
`default_nettype none

module selection_mask_pixel_update (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smpu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire logic [smpu_pkg::COORD_BITS-1:0] pixel_x,
    input  wire logic [smpu_pkg::COORD_BITS-1:0] pixel_y,
    input  wire logic [smpu_pkg::MASK_W-1:0]     old_mask,
    input  wire logic [smpu_pkg::CH_W-1:0]       red,
    input  wire logic [smpu_pkg::CH_W-1:0]       green,
    input  wire logic [smpu_pkg::CH_W-1:0]       blue,
    input  wire logic [smpu_pkg::CH_W-1:0]       alpha,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [smpu_pkg::MASK_W-1:0]          new_mask
);
    import smpu_pkg::*;

    smpu_cfg_t  cfg_reg;
    smpu_cfg_t  cfg_next;
    logic       push_valid;
    logic       push_ready;
    smpu_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    smpu_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHAPE_KIND:      cfg_next.shape_kind      = cfg_data[1:0];
                REG_COMBINE_OP:      cfg_next.combine_op      = cfg_data[1:0];
                REG_BOX_LEFT:        cfg_next.box_left        = cfg_data[COORD_BITS-1:0];
                REG_BOX_TOP:         cfg_next.box_top         = cfg_data[COORD_BITS-1:0];
                REG_BOX_RIGHT:       cfg_next.box_right       = cfg_data[COORD_BITS-1:0];
                REG_BOX_BOTTOM:      cfg_next.box_bottom      = cfg_data[COORD_BITS-1:0];
                REG_REFERENCE_COLOR: cfg_next.reference_color = cfg_data[31:0];
                REG_COLOR_TOLERANCE: cfg_next.color_tolerance = cfg_data[CH_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smpu_front u_front (
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .old_mask   (old_mask),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    smpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    smpu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .new_mask  (new_mask)
    );

endmodule

`default_nettype wire

// ----- sv/smpu_checker.sv -----
// Port-level checker for the selection mask pixel update block, with its bind.
// Depends on smpu_pkg and the top level's ports.
`default_nettype none

module smpu_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  in_valid,
    input wire                                  in_ready,
    input wire                                  out_valid,
    input wire                                  out_ready,
    input wire logic [smpu_pkg::MASK_W-1:0]     new_mask
);
    import smpu_pkg::*;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic              in_fire;
    logic              out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
        begin
            pend_next = pend_reg + PEND_W'(1);
        end
        else if (out_fire && !in_fire)
        begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A held result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the word was taken");

    // A held result word keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_mask))
        else $error("new_mask changed while stalled");

    // Every result word belongs to an accepted pixel word.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result offered with no pixel word outstanding");

    // The queue and the back end never hold more than their capacity.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(PIPE_CAPACITY))
        else $error("more pixel words outstanding than the block can hold");

endmodule

bind selection_mask_pixel_update smpu_checker u_smpu_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for selection_mask_pixel_update: directed table, then random phases.
// Depends on smpu_pkg and the selection_mask_pixel_update RTL only.

module tb_top;
    import smpu_pkg::*;

    localparam logic [1:0] SHAPE_OTHER = 2'd3;
    localparam logic [1:0] OP_OTHER    = 2'd3;
    localparam int LATENCY      = 3;
    localparam int RANDOM_WORDS = 1250;
    localparam bit PREDICTED    = 1'b0;
    localparam bit TYPED        = 1'b1;

    typedef struct packed {
        logic [1:0]                   shape;
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] bottom;
        logic [31:0]                  refc;
        logic [CH_W-1:0]              tol;
    } settings_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [MASK_W-1:0]            old;
        logic [CH_W-1:0]              red;
        logic [CH_W-1:0]              green;
        logic [CH_W-1:0]              blue;
        logic [CH_W-1:0]              alpha;
    } pixel_t;

    typedef struct {
        settings_t         cfg;
        pixel_t            px;
        bit                typed;
        logic [MASK_W-1:0] want;
    } row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [COORD_BITS-1:0] pixel_x   = '0;
    logic [COORD_BITS-1:0] pixel_y   = '0;
    logic [MASK_W-1:0]     old_mask  = '0;
    logic [CH_W-1:0]       red       = '0;
    logic [CH_W-1:0]       green     = '0;
    logic [CH_W-1:0]       blue      = '0;
    logic [CH_W-1:0]       alpha     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MASK_W-1:0]     new_mask;

    settings_t         live = '0;
    row_t              directed_rows[$];
    logic [MASK_W-1:0] pending_masks[$];
    logic [MASK_W-1:0] oldest_mask;
    bit                steady = 1'b0;
    int                fail_count = 0;
    int                words_sent = 0;
    int                masks_checked = 0;
    int                settings_applied = 0;

    selection_mask_pixel_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .old_mask  (old_mask),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .new_mask  (new_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] predict_mask(settings_t c, pixel_t p);
        longint      x, y, l, t, r, b, w, h, w1, h1, dx, dy;
        int          dr, dg, db, da;
        int unsigned sum, root, probe;
        logic        in_box, core, ring;
        logic [MASK_W-1:0] base, res;
        x = p.x;
        y = p.y;
        l = c.left;
        t = c.top;
        r = c.right;
        b = c.bottom;
        in_box = (x >= l) && (x < r) && (y >= t) && (y < b);
        base = (c.op == OP_REPLACE) ? MASK_EMPTY : p.old;
        res = p.old;
        core = 1'b0;
        ring = 1'b0;
        if (c.op > OP_SUBTRACT || c.shape > SHAPE_COLOR)
        begin
            res = p.old;
        end
        else if (c.shape == SHAPE_RECT)
        begin
            if (c.op == OP_SUBTRACT)
                res = in_box ? MASK_EMPTY : p.old;
            else
                res = in_box ? MASK_FULL : base;
        end
        else if (c.shape == SHAPE_ELLIPSE)
        begin
            if (in_box)
            begin
                w = r - l;
                h = b - t;
                w1 = w + 1;
                h1 = h + 1;
                dx = x - (l + r) / 2;
                dy = y - (t + b) / 2;
                core = (4 * dx * dx * h * h + 4 * dy * dy * w * w <= w * w * h * h);
                ring = !core &&
                    (4 * dx * dx * h1 * h1 + 4 * dy * dy * w1 * w1 <= w1 * w1 * h1 * h1);
            end
            if (c.op == OP_SUBTRACT)
                res = core ? MASK_EMPTY : (ring ? ((p.old < MASK_HALF) ? p.old : MASK_HALF)
                                                : p.old);
            else
                res = core ? MASK_FULL : (ring ? ((base > MASK_HALF) ? base : MASK_HALF)
                                               : base);
        end
        else if (c.op != OP_SUBTRACT)
        begin
            dr = int'(p.red) - int'(c.refc[23:16]);
            dg = int'(p.green) - int'(c.refc[15:8]);
            db = int'(p.blue) - int'(c.refc[7:0]);
            da = int'(p.alpha) - int'(c.refc[31:24]);
            sum = dr * dr + dg * dg + db * db + da * da;
            root = 0;
            for (probe = 1 << 18; probe != 0; probe = probe >> 1)
            begin
                if (longint'(root | probe) * longint'(root | probe) <= longint'(sum))
                    root = root | probe;
            end
            res = (root / 2 <= c.tol) ? MASK_FULL : base;
        end
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_word(settings_t c,
                                                       logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_SHAPE_KIND:      return CFG_DATA_W'(c.shape);
            REG_COMBINE_OP:      return CFG_DATA_W'(c.op);
            REG_BOX_LEFT:        return CFG_DATA_W'(c.left);
            REG_BOX_TOP:         return CFG_DATA_W'(c.top);
            REG_BOX_RIGHT:       return CFG_DATA_W'(c.right);
            REG_BOX_BOTTOM:      return CFG_DATA_W'(c.bottom);
            REG_REFERENCE_COLOR: return c.refc;
            REG_COLOR_TOLERANCE: return CFG_DATA_W'(c.tol);
            default:             return '0;
        endcase
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] near_channel(logic [CH_W-1:0] centre, int spread);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[CH_W-1:0];
    endfunction

    function automatic settings_t roll_settings();
        settings_t c;
        int        pick, lo;
        pick = $urandom_range(0, 19);
        c.shape = (pick < 6) ? SHAPE_RECT : (pick < 13) ? SHAPE_ELLIPSE :
                  (pick < 19) ? SHAPE_COLOR : SHAPE_OTHER;
        pick = $urandom_range(0, 15);
        c.op = (pick < 5) ? OP_REPLACE : (pick < 10) ? OP_ADD :
               (pick < 15) ? OP_SUBTRACT : OP_OTHER;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            c.left   = COORD_BITS'(-4096);
            c.top    = COORD_BITS'(-4096);
            c.right  = COORD_BITS'(4095);
            c.bottom = COORD_BITS'(4095);
        end
        else if (pick == 1)
        begin
            c.left   = COORD_BITS'($urandom);
            c.top    = COORD_BITS'($urandom);
            c.right  = COORD_BITS'($urandom);
            c.bottom = COORD_BITS'($urandom);
        end
        else if (pick == 2)
        begin
            lo = int'($urandom_range(0, 60)) - 30;
            c.left  = COORD_BITS'(lo);
            c.right = COORD_BITS'(lo - int'($urandom_range(0, 3)));
            lo = int'($urandom_range(0, 60)) - 30;
            c.top    = COORD_BITS'(lo);
            c.bottom = COORD_BITS'(lo + int'($urandom_range(0, 20)));
        end
        else
        begin
            lo = int'($urandom_range(0, 200)) - 100;
            c.left  = COORD_BITS'(lo);
            c.right = COORD_BITS'(lo + int'($urandom_range(1, 40)));
            lo = int'($urandom_range(0, 200)) - 100;
            c.top    = COORD_BITS'(lo);
            c.bottom = COORD_BITS'(lo + int'($urandom_range(1, 40)));
        end
        pick = $urandom_range(0, 5);
        c.refc = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(0, 5);
        c.tol = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : CH_W'($urandom_range(0, 40));
        return c;
    endfunction

    function automatic pixel_t roll_pixel(settings_t c);
        pixel_t p;
        int     pick, lo, span, spread;
        pick = $urandom_range(0, 9);
        p.old = MASK_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            p.old = 8'h7F + MASK_W'($urandom_range(0, 2));
        {p.alpha, p.red, p.green, p.blue} = $urandom;
        if (pick < 2)
        begin
            p.x = COORD_BITS'($urandom);
            p.y = COORD_BITS'($urandom);
        end
        else
        begin
            lo = c.left;
            span = int'(c.right) - lo;
            if (span < 0)
                span = 0;
            p.x = COORD_BITS'(lo - 3 + int'($urandom_range(0, span + 6)));
            lo = c.top;
            span = int'(c.bottom) - lo;
            if (span < 0)
                span = 0;
            p.y = COORD_BITS'(lo - 3 + int'($urandom_range(0, span + 6)));
            spread = $urandom_range(0, int'(c.tol) + 4);
            p.alpha = near_channel(c.refc[31:24], spread);
            p.red   = near_channel(c.refc[23:16], spread);
            p.green = near_channel(c.refc[15:8], spread);
            p.blue  = near_channel(c.refc[7:0], spread);
        end
        return p;
    endfunction

    task automatic add_row(logic [1:0] shape, logic [1:0] op, int l, int t, int r, int b,
                           logic [31:0] refc, int tol, int x, int y, int old,
                           logic [31:0] rgba, bit typed, int want);
        row_t row;
        row.cfg.shape  = shape;
        row.cfg.op     = op;
        row.cfg.left   = COORD_BITS'(l);
        row.cfg.top    = COORD_BITS'(t);
        row.cfg.right  = COORD_BITS'(r);
        row.cfg.bottom = COORD_BITS'(b);
        row.cfg.refc   = refc;
        row.cfg.tol    = CH_W'(tol);
        row.px.x       = COORD_BITS'(x);
        row.px.y       = COORD_BITS'(y);
        row.px.old     = MASK_W'(old);
        {row.px.alpha, row.px.red, row.px.green, row.px.blue} = rgba;
        row.typed      = typed;
        row.want       = MASK_W'(want);
        directed_rows.push_back(row);
    endtask

    task automatic apply_settings(settings_t c);
        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        for (int i = REG_SHAPE_KIND; i <= REG_COLOR_TOLERANCE; i++)
        begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= reg_word(c, CFG_IDX_W'(i));
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        live = c;
        settings_applied++;
    endtask

    task automatic send_pixel(pixel_t p, bit typed, logic [MASK_W-1:0] want);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_x  <= p.x;
        pixel_y  <= p.y;
        old_mask <= p.old;
        red      <= p.red;
        green    <= p.green;
        blue     <= p.blue;
        alpha    <= p.alpha;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_masks.push_back(typed ? want : predict_mask(live, p));
        words_sent++;
    endtask

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_masks.size() == 0)
            begin
                $error("new_mask: expected nothing, got %02h", new_mask);
                fail_count++;
            end
            else
            begin
                oldest_mask = pending_masks.pop_front();
                masks_checked++;
                if (new_mask !== oldest_mask)
                begin
                    $error("new_mask: expected %02h, got %02h", oldest_mask, new_mask);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int        target;
        settings_t c;
        target = 0;
        // Rows: shape, op, box l t r b, reference, tolerance, x, y, old, argb, check.
        add_row(SHAPE_RECT, OP_REPLACE, 0, 0, 0, 0, 32'h0, 0,
                0, 0, 8'hAB, 32'h0, TYPED, 8'h00);
        add_row(SHAPE_RECT, OP_REPLACE, -4096, -4096, 4095, 4095, 32'h0, 0,
                -4096, -4096, 8'h00, 32'h0, TYPED, 8'hFF);
        add_row(SHAPE_RECT, OP_ADD, -4096, -4096, 4095, 4095, 32'h0, 0,
                4095, 0, 8'h12, 32'hFFFF_FFFF, TYPED, 8'h12);
        add_row(SHAPE_RECT, OP_ADD, -4096, -4096, 4095, 4095, 32'h0, 0,
                4094, 4094, 8'h12, 32'h0, TYPED, 8'hFF);
        add_row(SHAPE_RECT, OP_SUBTRACT, -4096, -4096, 4095, 4095, 32'h0, 0,
                0, 0, 8'h77, 32'h0, TYPED, 8'h00);
        add_row(SHAPE_RECT, OP_SUBTRACT, -4096, -4096, 4095, 4095, 32'h0, 0,
                0, 4095, 8'h77, 32'h0, TYPED, 8'h77);
        add_row(SHAPE_RECT, OP_ADD, 10, 10, 5, 20, 32'h0, 0,
                7, 12, 8'h5A, 32'h0, TYPED, 8'h5A);
        add_row(SHAPE_RECT, OP_ADD, 3, 3, 3, 3, 32'h0, 0,
                3, 3, 8'h5A, 32'h0, TYPED, 8'h5A);
        add_row(SHAPE_RECT, OP_OTHER, -4096, -4096, 4095, 4095, 32'h0, 0,
                0, 0, 8'h3C, 32'h0, TYPED, 8'h3C);
        add_row(SHAPE_OTHER, OP_ADD, -4096, -4096, 4095, 4095, 32'h0, 0,
                0, 0, 8'hC3, 32'h0, TYPED, 8'hC3);
        add_row(SHAPE_ELLIPSE, OP_ADD, 0, 0, 16, 16, 32'h0, 0,
                8, 8, 8'h00, 32'h0, TYPED, 8'hFF);
        add_row(SHAPE_ELLIPSE, OP_ADD, 0, 0, 16, 16, 32'h0, 0,
                0, 3, 8'h10, 32'h0, PREDICTED, 0);
        add_row(SHAPE_ELLIPSE, OP_ADD, 0, 0, 16, 16, 32'h0, 0,
                1, 2, 8'h90, 32'h0, PREDICTED, 0);
        add_row(SHAPE_ELLIPSE, OP_REPLACE, 0, 0, 16, 16, 32'h0, 0,
                0, 0, 8'hFF, 32'h0, PREDICTED, 0);
        add_row(SHAPE_ELLIPSE, OP_SUBTRACT, 0, 0, 16, 16, 32'h0, 0,
                8, 8, 8'h44, 32'h0, TYPED, 8'h00);
        add_row(SHAPE_ELLIPSE, OP_SUBTRACT, 0, 0, 16, 16, 32'h0, 0,
                1, 2, 8'hC0, 32'h0, PREDICTED, 0);
        add_row(SHAPE_ELLIPSE, OP_SUBTRACT, 0, 0, 16, 16, 32'h0, 0,
                16, 8, 8'hC0, 32'h0, TYPED, 8'hC0);
        add_row(SHAPE_ELLIPSE, OP_ADD, 5, 5, 6, 6, 32'h0, 0,
                5, 5, 8'h00, 32'h0, PREDICTED, 0);
        add_row(SHAPE_ELLIPSE, OP_ADD, -4096, -4096, 4095, 4095, 32'h0, 0,
                0, 0, 8'h20, 32'h0, TYPED, 8'hFF);
        add_row(SHAPE_ELLIPSE, OP_ADD, -4096, -4096, 4095, 4095, 32'h0, 0,
                -4096, -1, 8'h20, 32'h0, PREDICTED, 0);
        add_row(SHAPE_COLOR, OP_REPLACE, 0, 0, 0, 0, 32'h1122_3344, 0,
                0, 0, 8'h55, 32'h1122_3344, TYPED, 8'hFF);
        add_row(SHAPE_COLOR, OP_REPLACE, 0, 0, 0, 0, 32'h0, 255,
                0, 0, 8'h00, 32'hFFFF_FFFF, TYPED, 8'hFF);
        add_row(SHAPE_COLOR, OP_ADD, 0, 0, 0, 0, 32'h0, 254,
                0, 0, 8'h33, 32'hFFFF_FFFF, TYPED, 8'h33);
        add_row(SHAPE_COLOR, OP_SUBTRACT, 0, 0, 0, 0, 32'h0, 255,
                0, 0, 8'h66, 32'h0, TYPED, 8'h66);
        add_row(SHAPE_COLOR, OP_ADD, 0, 0, 0, 0, 32'hFFFF_FFFF, 3,
                0, 0, 8'h01, 32'hF8FF_F9FF, PREDICTED, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg != live)
                apply_settings(directed_rows[i].cfg);
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        end

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            c = roll_settings();
            steady = ($urandom_range(0, 4) == 0);
            apply_settings(c);
            repeat ($urandom_range(30, 90)) send_pixel(roll_pixel(live), PREDICTED, '0);
        end

        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        $display("Sent %0d pixel words under %0d register settings, compared %0d masks.",
                 words_sent, settings_applied, masks_checked);
        $display("Covered rectangle, ellipse and color range shapes, all combine codes.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d masks still pending.", pending_masks.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
